### hdl/tss_pkg.sv
// Package for the touch sample to screen mapper.
// Holds payload structs, opcodes, register indexes, phase codes and the
// controller state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int unsigned VAL_W    = 12;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DCNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] OP_Z1    = 2'd0;
  localparam logic [1:0] OP_X     = 2'd1;
  localparam logic [1:0] OP_Y     = 2'd2;
  localparam logic [1:0] OP_PENUP = 2'd3;

  localparam logic [1:0] PH_Z1 = 2'd0;
  localparam logic [1:0] PH_X  = 2'd1;
  localparam logic [1:0] PH_Y  = 2'd2;

  localparam logic [IDX_W-1:0] REG_THRESH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_MIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_MAX    = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_MIN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_MAX    = 3'd4;
  localparam logic [IDX_W-1:0] REG_ORIENT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
  } tss_in_t;

  typedef struct packed {
    logic             pressed;
    logic [VAL_W-1:0] screen_x;
    logic [VAL_W-1:0] screen_y;
    logic [VAL_W-1:0] raw_x;
    logic [VAL_W-1:0] raw_y;
    logic             raw_valid;
  } tss_out_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_start;
    logic axis_y;
    logic cap_q;
    logic fin;
    logic load_out;
  } tss_cmd_t;

  typedef struct packed {
    logic emit_np;
    logic need_map;
    logic div_done;
  } tss_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MAP_X,
    S_DIV_X,
    S_MAP_Y,
    S_DIV_Y,
    S_FIN,
    S_EMIT
  } tss_state_t;

endpackage
`default_nettype wire

### hdl/tss_div.sv
// Restoring divider, one quotient bit per cycle.
// Unsigned product by unsigned divisor. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tss_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tss_pkg::PROD_W-1:0]   dividend,
  input  wire logic [tss_pkg::VAL_W-1:0]    divisor,
  output logic                              done,
  output logic [tss_pkg::PROD_W-1:0]        quotient
);
  import tss_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic [VAL_W-1:0]    rem_r;
  logic [VAL_W-1:0]    rem_nxt;
  logic [PROD_W-1:0]   q_r;
  logic [PROD_W-1:0]   q_nxt;
  logic [VAL_W:0]      shifted;
  logic [VAL_W:0]      trial;

  always_comb begin
    shifted = {rem_r, q_r[PROD_W-1]};
    trial   = shifted - {1'b0, divisor};
    if (shifted >= {1'b0, divisor}) begin
      rem_nxt = trial[VAL_W-1:0];
      q_nxt   = {q_r[PROD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[VAL_W-1:0];
      q_nxt   = {q_r[PROD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### hdl/tss_datapath.sv
// Datapath: configuration registers, sample averaging, touch state,
// linear mapping with the shared divider, and the result register.
// Depends on tss_pkg and tss_div.
`timescale 1ns / 1ps
`default_nettype none
module tss_datapath #(
  parameter int unsigned SAMPLES = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tss_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [tss_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire tss_pkg::tss_in_t            in_data,
  input  wire tss_pkg::tss_cmd_t           cmd,
  output tss_pkg::tss_stat_t               stat,
  input  wire logic                        out_valid,
  output tss_pkg::tss_out_t                out_data
);
  import tss_pkg::*;

  // divide by three as multiply by reciprocal and shift
  localparam int unsigned RECIP3    = 43691;
  localparam int unsigned RECIP3_SH = 17;

  logic [VAL_W-1:0] thresh_r, x_min_r, x_max_r, y_min_r, y_max_r, width_r, height_r;
  logic [2:0]       orient_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [VAL_W-1:0] held_x_r, last_x_r, last_y_r;
  logic             last_valid_r;
  tss_in_t          in_r;

  logic [VAL_W-1:0] val;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      avg_prod;
  logic [SUM_W-1:0] avg_full;
  logic [VAL_W-1:0] avg;
  logic [1:0]       phase_eff;
  logic [1:0]       want;
  logic             is_penup, match, done_ch, below;

  logic [VAL_W-1:0]  map_v, map_lo, map_hi, map_size;
  logic signed [VAL_W:0] diff;
  logic [VAL_W-1:0]  mag;
  logic [VAL_W-1:0]  den;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;
  logic              div_done;
  logic              neg_r;
  logic [VAL_W-1:0]  den_r;
  logic signed [PROD_W:0] qs;
  logic signed [PROD_W:0] qx_r, qy_r;
  logic signed [PROD_W+1:0] xs, ys;
  logic [VAL_W-1:0]  fx, fy;

  logic             pend_pressed_r;
  logic [VAL_W-1:0] pend_x_r, pend_y_r;
  tss_out_t         out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 12'd100;
      x_min_r  <= 12'd200;
      x_max_r  <= 12'd3900;
      y_min_r  <= 12'd200;
      y_max_r  <= 12'd3900;
      orient_r <= 3'd0;
      width_r  <= 12'd320;
      height_r <= 12'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH: thresh_r <= cfg_wdata;
        REG_X_MIN:  x_min_r  <= cfg_wdata;
        REG_X_MAX:  x_max_r  <= cfg_wdata;
        REG_Y_MIN:  y_min_r  <= cfg_wdata;
        REG_Y_MAX:  y_max_r  <= cfg_wdata;
        REG_ORIENT: orient_r <= cfg_wdata[2:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    thresh_r <= thresh_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  // sample decode and averaging
  always_comb begin
    val       = {in_r.hi_byte[6:0], in_r.lo_byte[7:3]};
    sum_add   = sum_r + SUM_W'(val);
    cnt_inc   = cnt_r + CNT_W'(1);
    avg_prod  = 32'(sum_add) * 32'(RECIP3);
    if (SAMPLES == 1) begin
      avg_full = sum_add;
    end else if (SAMPLES == 2) begin
      avg_full = sum_add >> 1;
    end else begin
      avg_full = SUM_W'(avg_prod >> RECIP3_SH);
    end
    avg       = avg_full[VAL_W-1:0];
    phase_eff = (phase_r == PH_X || phase_r == PH_Y) ? phase_r : PH_Z1;
    unique case (phase_eff)
      PH_X:    want = OP_X;
      PH_Y:    want = OP_Y;
      default: want = OP_Z1;
    endcase
    is_penup = (in_r.op == OP_PENUP);
    match    = !is_penup && (in_r.op == want);
    done_ch  = ({30'd0, cnt_inc} >= 32'(SAMPLES));
    below    = (avg < thresh_r);
  end

  always_comb begin
    phase_nxt = phase_eff;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    if (is_penup) begin
      phase_nxt = PH_Z1;
      cnt_nxt   = '0;
      sum_nxt   = '0;
    end else if (match) begin
      if (!done_ch) begin
        cnt_nxt = cnt_inc;
        sum_nxt = sum_add;
      end else begin
        cnt_nxt = '0;
        sum_nxt = '0;
        unique case (phase_eff)
          PH_X:    phase_nxt = PH_Y;
          PH_Y:    phase_nxt = PH_Z1;
          default: phase_nxt = below ? PH_Z1 : PH_X;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_Z1;
      cnt_r        <= '0;
      sum_r        <= '0;
      held_x_r     <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      last_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      if (match && done_ch && phase_eff == PH_X) begin
        held_x_r <= avg;
      end
      if (match && done_ch && phase_eff == PH_Y) begin
        last_x_r     <= held_x_r;
        last_y_r     <= avg;
        last_valid_r <= 1'b1;
      end
    end
  end

  assign stat.emit_np  = is_penup || (match && done_ch && phase_eff == PH_Z1 && below);
  assign stat.need_map = match && done_ch && phase_eff == PH_Y;
  assign stat.div_done = div_done;

  // linear map operands for the selected axis
  always_comb begin
    if (cmd.axis_y) begin
      map_v    = orient_r[0] ? last_x_r : last_y_r;
      map_lo   = y_min_r;
      map_hi   = y_max_r;
      map_size = height_r;
    end else begin
      map_v    = orient_r[0] ? last_y_r : last_x_r;
      map_lo   = x_min_r;
      map_hi   = x_max_r;
      map_size = width_r;
    end
    diff = $signed({1'b0, map_v}) - $signed({1'b0, map_lo});
    mag  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    den  = (map_hi > map_lo) ? (map_hi - map_lo) : VAL_W'(1);
    prod = PROD_W'(mag) * PROD_W'(map_size);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= diff[VAL_W];
      den_r <= den;
    end
  end

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  assign qs = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (cmd.cap_q) begin
      if (cmd.axis_y) begin
        qy_r <= qs;
      end else begin
        qx_r <= qs;
      end
    end
  end

  // invert and clamp
  always_comb begin
    xs = orient_r[1] ? ($signed({2'b00, 12'd0, width_r}) - {qx_r[PROD_W], qx_r})
                     : {qx_r[PROD_W], qx_r};
    ys = orient_r[2] ? ($signed({2'b00, 12'd0, height_r}) - {qy_r[PROD_W], qy_r})
                     : {qy_r[PROD_W], qy_r};
    if (xs[PROD_W+1]) begin
      fx = '0;
    end else if (xs > $signed({2'b00, 12'd0, width_r})) begin
      fx = width_r;
    end else begin
      fx = xs[VAL_W-1:0];
    end
    if (ys[PROD_W+1]) begin
      fy = '0;
    end else if (ys > $signed({2'b00, 12'd0, height_r})) begin
      fy = height_r;
    end else begin
      fy = ys[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pend_pressed_r <= 1'b0;
      pend_x_r       <= '0;
      pend_y_r       <= '0;
    end else if (cmd.fin) begin
      pend_pressed_r <= 1'b1;
      pend_x_r       <= fx;
      pend_y_r       <= fy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.pressed   <= pend_pressed_r;
      out_r.screen_x  <= pend_x_r;
      out_r.screen_y  <= pend_y_r;
      out_r.raw_x     <= last_x_r;
      out_r.raw_y     <= last_y_r;
      out_r.raw_valid <= last_valid_r;
    end
  end

  assign out_data = out_r;

  a_pressed_has_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pressed |-> out_data.raw_valid)
    else $error("pressed result without captured raw pair");

  a_np_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressed |-> out_data.screen_x == '0 && out_data.screen_y == '0)
    else $error("not-pressed result with nonzero coordinates");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> den_r != '0)
    else $error("mapping started with zero span");

endmodule
`default_nettype wire

### hdl/tss_ctrl.sv
// Controller: sequences capture, evaluation, the two mapping divisions
// and the result handoff. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tss_pkg::tss_stat_t stat,
  output tss_pkg::tss_cmd_t       cmd
);
  import tss_pkg::*;

  tss_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (stat.emit_np) begin
          state_nxt = S_EMIT;
        end else if (stat.need_map) begin
          state_nxt = S_MAP_X;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAP_X: state_nxt = S_DIV_X;
      S_DIV_X: if (stat.div_done) state_nxt = S_MAP_Y;
      S_MAP_Y: state_nxt = S_DIV_Y;
      S_DIV_Y: if (stat.div_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EVAL:  cmd.eval = 1'b1;
      S_MAP_X: cmd.div_start = 1'b1;
      S_DIV_X: cmd.cap_q = stat.div_done;
      S_MAP_Y: begin
        cmd.div_start = 1'b1;
        cmd.axis_y    = 1'b1;
      end
      S_DIV_Y: begin
        cmd.cap_q  = stat.div_done;
        cmd.axis_y = 1'b1;
      end
      S_FIN:   cmd.fin = 1'b1;
      S_EMIT:  cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r || out_ready)
    else $error("result register overwritten before it was taken");

  a_map_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAP_X |-> $past(state_r) == S_EVAL && $past(stat.need_map))
    else $error("mapping started without a complete sample set");

endmodule
`default_nettype wire

### hdl/touch_sample_to_screen.sv
// Top level of the touch sample to screen mapper.
// Joins tss_ctrl and tss_datapath. Depends on tss_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one converter reply (op, hi_byte, lo_byte)
//   or a pen-up request. out_valid/out_ready/out_data carry one result:
//   pressed flag, mapped screen_x/screen_y and the last captured raw pair.
//   cfg_we/cfg_index/cfg_wdata write the eight calibration and screen
//   registers, one per write; write them only while the block is idle.
//   One request is in work at a time. A request that yields no result
//   passes through S_EVAL and then frees the input. A pen-up or
//   low-pressure result goes through S_EVAL and S_EMIT into the output register.
//   The request that completes a Z1/X/Y set runs both axes through one
//   shared restoring divider, one quotient bit a cycle, first X and then Y,
//   before S_FIN and S_EMIT hand its result to the output register.
//   A finished result waits in the output register while out_ready is low;
//   the block takes the next request meanwhile and holds only when a new
//   result is ready to replace one still waiting.
//   Synchronous reset returns all touch state to idle, the output to empty
//   and the registers to their default calibration.
`timescale 1ns / 1ps
`default_nettype none
module touch_sample_to_screen #(
  parameter int unsigned SAMPLES = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tss_pkg::tss_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tss_pkg::tss_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic [tss_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [tss_pkg::CFG_W-1:0]   cfg_wdata
);
  import tss_pkg::*;

  tss_cmd_t  cmd;
  tss_stat_t stat;

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tss_datapath #(
    .SAMPLES (SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// Bench for touch_sample_to_screen: streams converter replies and pen-up requests,
// rewrites the calibration between runs and checks every report against an
// in-bench model of averaging, pressure gating and screen mapping. Uses tss_pkg.
module tb_top;
  import tss_pkg::*;

  localparam int SAMPLES      = 3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT        = 400000;
  localparam int N_SETTINGS   = 8;
  localparam int MIX_ITEMS    = 120;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  tss_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tss_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  touch_sample_to_screen #(.SAMPLES(SAMPLES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tss_in_t     reply_q[$];
  tss_out_t    pending_reports[$];
  logic [11:0] cal_reg[8];
  int unsigned next_cal[8];

  logic [1:0]  trk_phase;
  logic [1:0]  trk_count;
  logic [13:0] trk_sum;
  logic [11:0] trk_held_x;
  logic [11:0] trk_last_x;
  logic [11:0] trk_last_y;
  logic        trk_last_valid;

  bit  no_gaps     = 1'b0;
  int  n_loaded    = 0;
  int  n_accepted  = 0;
  int  n_reports   = 0;
  int  n_touch     = 0;
  int  n_release   = 0;
  int  n_errors    = 0;
  int  n_cycles    = 0;
  int  n_settings  = 1;
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  tss_out_t want_report;

  function automatic longint scale_axis(longint v, longint lo, longint hi, longint size);
    if (hi <= lo) hi = lo + 1;
    return ((v - lo) * size) / (hi - lo);
  endfunction

  function automatic longint clamp_axis(longint v, longint size);
    if (v < 0) return 0;
    if (v > size) return size;
    return v;
  endfunction

  function automatic void note_report(logic pr, longint sx, longint sy);
    tss_out_t rep;
    rep.pressed   = pr;
    rep.screen_x  = sx[11:0];
    rep.screen_y  = sy[11:0];
    rep.raw_x     = trk_last_x;
    rep.raw_y     = trk_last_y;
    rep.raw_valid = trk_last_valid;
    pending_reports.push_back(rep);
    if (pr) n_touch++;
    else n_release++;
  endfunction

  function automatic void predict_reply(tss_in_t r);
    logic [1:0]  want_op;
    logic [11:0] val;
    logic [11:0] avg;
    longint      w, h, x, y, rx, ry;
    if (r.op == OP_PENUP) begin
      trk_phase = PH_Z1;
      trk_count = '0;
      trk_sum   = '0;
      note_report(1'b0, 0, 0);
      return;
    end
    if (trk_phase > PH_Y) trk_phase = PH_Z1;
    want_op = (trk_phase == PH_Z1) ? OP_Z1 : (trk_phase == PH_X) ? OP_X : OP_Y;
    if (r.op != want_op) return;
    val = {r.hi_byte[6:0], r.lo_byte[7:3]};
    trk_sum   = trk_sum + val;
    trk_count = trk_count + 2'd1;
    if (trk_count < SAMPLES) return;
    avg = trk_sum / SAMPLES;
    trk_count = '0;
    trk_sum   = '0;
    if (trk_phase == PH_Z1) begin
      if (avg < cal_reg[REG_THRESH]) note_report(1'b0, 0, 0);
      else trk_phase = PH_X;
      return;
    end
    if (trk_phase == PH_X) begin
      trk_held_x = avg;
      trk_phase  = PH_Y;
      return;
    end
    trk_phase      = PH_Z1;
    trk_last_x     = trk_held_x;
    trk_last_y     = avg;
    trk_last_valid = 1'b1;
    w  = cal_reg[REG_WIDTH];
    h  = cal_reg[REG_HEIGHT];
    rx = trk_last_x;
    ry = trk_last_y;
    if (cal_reg[REG_ORIENT][0]) begin
      x = scale_axis(ry, cal_reg[REG_X_MIN], cal_reg[REG_X_MAX], w);
      y = scale_axis(rx, cal_reg[REG_Y_MIN], cal_reg[REG_Y_MAX], h);
    end else begin
      x = scale_axis(rx, cal_reg[REG_X_MIN], cal_reg[REG_X_MAX], w);
      y = scale_axis(ry, cal_reg[REG_Y_MIN], cal_reg[REG_Y_MAX], h);
    end
    if (cal_reg[REG_ORIENT][1]) x = w - x;
    if (cal_reg[REG_ORIENT][2]) y = h - y;
    note_report(1'b1, clamp_axis(x, w), clamp_axis(y, h));
  endfunction

  function automatic string fmt_report(tss_out_t r);
    return $sformatf("pressed=%0d x=%0d y=%0d raw=%0d/%0d raw_valid=%0d",
                     r.pressed, r.screen_x, r.screen_y, r.raw_x, r.raw_y, r.raw_valid);
  endfunction

  function automatic tss_in_t raw_reply(logic [1:0] op, logic [7:0] hi, logic [7:0] lo);
    tss_in_t r;
    r.op      = op;
    r.hi_byte = hi;
    r.lo_byte = lo;
    return r;
  endfunction

  function automatic tss_in_t make_reply(logic [1:0] op, logic [11:0] v);
    return raw_reply(op, {1'($urandom_range(0, 1)), v[11:5]},
                     {v[4:0], 3'($urandom_range(0, 7))});
  endfunction

  task automatic queue_channel(logic [1:0] op, int v, int jit);
    int s;
    for (int i = 0; i < SAMPLES; i++) begin
      s = v + int'($urandom_range(0, 2 * jit)) - jit;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      reply_q.push_back(make_reply(op, s[11:0]));
    end
  endtask

  task automatic queue_penup();
    reply_q.push_back(make_reply(OP_PENUP, 12'($urandom)));
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return cal_reg[REG_X_MIN];
      1: return cal_reg[REG_X_MAX];
      2: return cal_reg[REG_Y_MIN];
      3: return cal_reg[REG_Y_MAX];
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic queue_mix(int n_items);
    int thr, pick, jit, target;
    thr    = cal_reg[REG_THRESH];
    target = reply_q.size() + n_items;
    while (reply_q.size() < target) begin
      pick = $urandom_range(0, 99);
      jit  = ($urandom_range(0, 3) == 0) ? 0 : 3;
      if (pick < 55) begin
        queue_channel(OP_Z1, $urandom_range(thr, 4095), jit);
        queue_channel(OP_X, pick_coord(), jit);
        queue_channel(OP_Y, pick_coord(), jit);
      end else if (pick < 70) begin
        if (thr > 0) queue_channel(OP_Z1, $urandom_range(0, thr - 1), 0);
        else queue_penup();
      end else if (pick < 80) begin
        queue_penup();
      end else if (pick < 90) begin
        queue_channel(OP_Z1, $urandom_range(thr, 4095), 0);
        repeat ($urandom_range(0, 2)) reply_q.push_back(make_reply(OP_X, 12'($urandom)));
        queue_penup();
      end else begin
        repeat ($urandom_range(1, 3)) reply_q.push_back(tss_in_t'($urandom));
        queue_penup();
      end
    end
  endtask

  task automatic load_calibration();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= next_cal[i][CFG_W-1:0];
      cal_reg[i] = (i == REG_ORIENT) ? 12'(next_cal[i] & 7) : next_cal[i][11:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (reply_q.size() != 0 || n_loaded != n_accepted || pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", n_cycles,
               pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reply(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (reply_q.size() != 0) begin
          in_data  <= reply_q.pop_front();
          in_valid <= 1'b1;
          n_loaded++;
          gap_left = no_gaps ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_reports++;
        if (pending_reports.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected report: %s", fmt_report(out_data));
        end else begin
          want_report = pending_reports.pop_front();
          if (out_data.pressed !== want_report.pressed ||
              out_data.screen_x !== want_report.screen_x ||
              out_data.screen_y !== want_report.screen_y ||
              out_data.raw_x !== want_report.raw_x ||
              out_data.raw_y !== want_report.raw_y ||
              out_data.raw_valid !== want_report.raw_valid) begin
            n_errors++;
            if (n_errors <= 10)
              $display("report %0d mismatch: expected %s, got %s", n_reports,
                       fmt_report(want_report), fmt_report(out_data));
          end
        end
        if (n_reports == 40 || n_reports == 100) hold_left = HOLD_CYCLES;
        stall_left = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cal_reg[REG_THRESH] = 12'd100;
    cal_reg[REG_X_MIN]  = 12'd200;
    cal_reg[REG_X_MAX]  = 12'd3900;
    cal_reg[REG_Y_MIN]  = 12'd200;
    cal_reg[REG_Y_MAX]  = 12'd3900;
    cal_reg[REG_ORIENT] = 12'd0;
    cal_reg[REG_WIDTH]  = 12'd320;
    cal_reg[REG_HEIGHT] = 12'd240;
    trk_phase      = PH_Z1;
    trk_count      = '0;
    trk_sum        = '0;
    trk_held_x     = '0;
    trk_last_x     = '0;
    trk_last_y     = '0;
    trk_last_valid = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // pen up, stray X while idle, zero pressure with busy and padding set
    reply_q.push_back(raw_reply(OP_PENUP, 8'hFF, 8'hFF));
    reply_q.push_back(raw_reply(OP_X, 8'hFF, 8'hFF));
    repeat (3) reply_q.push_back(raw_reply(OP_Z1, 8'h80, 8'h07));
    // full pressure, X at zero with stray channels, Y at full scale
    repeat (3) reply_q.push_back(raw_reply(OP_Z1, 8'hFF, 8'hFF));
    reply_q.push_back(raw_reply(OP_X, 8'h00, 8'h00));
    reply_q.push_back(raw_reply(OP_Y, 8'h7F, 8'hF8));
    reply_q.push_back(raw_reply(OP_Z1, 8'h7F, 8'hF8));
    repeat (2) reply_q.push_back(raw_reply(OP_X, 8'h00, 8'h00));
    repeat (3) reply_q.push_back(raw_reply(OP_Y, 8'h7F, 8'hF8));
    // pen up in the middle of a set, then pressure one below threshold
    queue_channel(OP_Z1, 2000, 0);
    reply_q.push_back(make_reply(OP_X, 12'd1000));
    queue_penup();
    queue_channel(OP_Z1, 99, 0);
    wait_idle();

    for (int k = 0; k < N_SETTINGS; k++) begin
      case (k)
        0: next_cal = '{0, 0, 4095, 0, 4095, 0, 2048, 2048};
        1: next_cal = '{4000, 4095, 0, 1000, 1000, 7, 1, 1};
        2: next_cal = '{50, 100, 4000, 3900, 150, 3, 4095, 0};
        3: next_cal = '{4095, 0, 4095, 4095, 0, 5, 0, 4095};
        default: begin
          next_cal[REG_THRESH] = $urandom_range(0, 1023);
          next_cal[REG_X_MIN]  = $urandom_range(0, 1500);
          next_cal[REG_X_MAX]  = $urandom_range(2500, 4095);
          next_cal[REG_Y_MIN]  = $urandom_range(0, 1500);
          next_cal[REG_Y_MAX]  = $urandom_range(2500, 4095);
          next_cal[REG_ORIENT] = $urandom_range(0, 7);
          next_cal[REG_WIDTH]  = $urandom_range(1, 2048);
          next_cal[REG_HEIGHT] = $urandom_range(1, 2048);
        end
      endcase
      load_calibration();
      n_settings++;
      no_gaps = (k % 3 == 2);
      queue_mix(MIX_ITEMS);
      wait_idle();
    end

    $display("Covered %0d requests over %0d calibration settings.", n_accepted, n_settings);
    $display("Checked %0d touch reports and %0d no-touch reports, %0d mismatches.",
             n_touch, n_release, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
